[sv/bhq_pkg.sv]
// Package with the types, constants and codes shared by the heap queue modules.
`default_nettype none

package bhq_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 24;
  localparam int TAG_BITS = 16;
  localparam int SLOT_BITS = 8;
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_EDIT = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [SLOT_BITS-1:0] slot;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic [CNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_ROOT,
    S_RD_LAST,
    S_GET_LAST,
    S_ED_RD,
    S_ED_CMP,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_RL,
    S_DN_RR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

[sv/bhq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/binary_min_heap_queue.sv]
// Top level of the binary min-heap priority queue: sequencer, sift datapath and store.
//
//  channel   ports                 handshake
//  -------   -------------------   ---------------------------------------------
//  command   item (item_t)         taken at a clock edge with start high, busy low
//  result    result (result_t)     valid for one cycle while done is high
//
// Each command is one transaction. A push climbs one level at a time from the new last slot;
// a pop reads the root and the last entry, then sinks the last entry one level at a time from
// the root; an edit reads its slot before its sift and skips the sift for an equal key. Errors
// and the unused code go straight to the response state. Reset (synchronous) empties the
// queue at once; the RAM is not cleared. The receiver cannot stall.
`default_nettype none

module binary_min_heap_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bhq_pkg::item_t   item,
  output logic                  busy,
  output logic                  done,
  output bhq_pkg::result_t      result
);

  localparam int AW = bhq_pkg::ADDR_W;
  localparam int CW = bhq_pkg::CNT_W;

  bhq_pkg::state_t state, state_next;

  logic [CW-1:0] fill_count;
  logic [AW-1:0] pos;
  bhq_pkg::entry_t cur;
  bhq_pkg::entry_t lft;
  logic [1:0] status;
  logic [bhq_pkg::KEY_BITS-1:0] out_key;
  logic [bhq_pkg::TAG_BITS-1:0] out_tag;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [bhq_pkg::ENTRY_W-1:0] ram_wdata;
  logic [bhq_pkg::ENTRY_W-1:0] ram_rdata;
  bhq_pkg::entry_t rd_entry;

  logic accept;
  logic [AW+1:0] lidx;
  logic [AW+1:0] ridx;
  logic [AW+1:0] fill_ext;
  logic l_in;
  logic r_in;
  logic pick_right;
  bhq_pkg::entry_t best;
  logic [AW-1:0] best_idx;
  logic [AW-1:0] parent_idx;
  logic sink_more;
  logic lift_more;

  bhq_ram #(
    .WIDTH(bhq_pkg::ENTRY_W),
    .DEPTH(bhq_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry = bhq_pkg::entry_t'(ram_rdata);
  assign accept = start && !busy;

  // Child positions need two extra bits so the right child of the last slot cannot wrap.
  assign lidx = {1'b0, pos, 1'b1};
  assign ridx = lidx + (AW+2)'(1);
  assign fill_ext = (AW+2)'(fill_count);
  assign l_in = lidx < fill_ext;
  assign r_in = ridx < fill_ext;
  assign pick_right = r_in && (rd_entry.key < lft.key);
  assign best = pick_right ? rd_entry : lft;
  assign best_idx = pick_right ? ridx[AW-1:0] : lidx[AW-1:0];
  assign sink_more = cur.key > best.key;
  assign parent_idx = AW'((pos - AW'(1)) >> 1);
  assign lift_more = cur.key < rd_entry.key;

  always_comb begin
    state_next = state;
    case (state)
      bhq_pkg::S_IDLE: begin
        if (accept) begin
          case (item.cmd)
            bhq_pkg::CMD_PUSH: begin
              state_next = (fill_count >= CW'(bhq_pkg::CAPACITY)) ? bhq_pkg::S_RESP
                                                                   : bhq_pkg::S_UP_CHK;
            end
            bhq_pkg::CMD_POP: begin
              state_next = (fill_count == '0) ? bhq_pkg::S_RESP : bhq_pkg::S_RD_ROOT;
            end
            bhq_pkg::CMD_EDIT: begin
              state_next = (CW'(item.slot) >= fill_count) ? bhq_pkg::S_RESP
                                                          : bhq_pkg::S_ED_RD;
            end
            default: state_next = bhq_pkg::S_RESP;
          endcase
        end
      end
      bhq_pkg::S_RD_ROOT:  state_next = bhq_pkg::S_RD_LAST;
      bhq_pkg::S_RD_LAST:  state_next = bhq_pkg::S_GET_LAST;
      bhq_pkg::S_GET_LAST: state_next = bhq_pkg::S_DN_CHK;
      bhq_pkg::S_ED_RD:    state_next = bhq_pkg::S_ED_CMP;
      bhq_pkg::S_ED_CMP: begin
        if (cur.key > rd_entry.key) begin
          state_next = bhq_pkg::S_DN_CHK;
        end else if (cur.key < rd_entry.key) begin
          state_next = bhq_pkg::S_UP_CHK;
        end else begin
          state_next = bhq_pkg::S_RESP;
        end
      end
      bhq_pkg::S_UP_CHK: state_next = (pos == '0) ? bhq_pkg::S_RESP : bhq_pkg::S_UP_CMP;
      bhq_pkg::S_UP_CMP: state_next = lift_more ? bhq_pkg::S_UP_CHK : bhq_pkg::S_RESP;
      bhq_pkg::S_DN_CHK: state_next = l_in ? bhq_pkg::S_DN_RL : bhq_pkg::S_RESP;
      bhq_pkg::S_DN_RL:  state_next = bhq_pkg::S_DN_RR;
      bhq_pkg::S_DN_RR:  state_next = sink_more ? bhq_pkg::S_DN_CHK : bhq_pkg::S_RESP;
      bhq_pkg::S_RESP:   state_next = bhq_pkg::S_IDLE;
      default:           state_next = bhq_pkg::S_IDLE;
    endcase
  end

  // The moving entry is kept in cur and written once into the hole where it settles;
  // entries it passes are shifted into the hole one level at a time.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur;
    ram_raddr = '0;
    case (state)
      bhq_pkg::S_RD_ROOT: ram_raddr = '0;
      bhq_pkg::S_RD_LAST: ram_raddr = fill_count[AW-1:0];
      bhq_pkg::S_ED_RD:   ram_raddr = pos;
      bhq_pkg::S_UP_CHK: begin
        ram_raddr = parent_idx;
        ram_we = (pos == '0);
      end
      bhq_pkg::S_UP_CMP: begin
        ram_we = 1'b1;
        ram_wdata = lift_more ? rd_entry : cur;
      end
      bhq_pkg::S_DN_CHK: begin
        ram_raddr = lidx[AW-1:0];
        ram_we = !l_in;
      end
      bhq_pkg::S_DN_RL: ram_raddr = ridx[AW-1:0];
      bhq_pkg::S_DN_RR: begin
        ram_we = 1'b1;
        ram_wdata = sink_more ? best : cur;
      end
      default: ram_raddr = '0;
    endcase
  end

  always_comb begin
    busy = (state != bhq_pkg::S_IDLE);
    done = (state == bhq_pkg::S_RESP);
    result.status = status;
    result.out_key = out_key;
    result.out_tag = out_tag;
    result.entry_count = fill_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhq_pkg::S_IDLE;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (item.cmd)
          bhq_pkg::CMD_PUSH: begin
            if (fill_count < CW'(bhq_pkg::CAPACITY)) begin
              fill_count <= fill_count + CW'(1);
            end
          end
          bhq_pkg::CMD_POP: begin
            if (fill_count != '0) begin
              fill_count <= fill_count - CW'(1);
            end
          end
          default: fill_count <= fill_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bhq_pkg::S_IDLE: begin
        if (accept) begin
          status <= bhq_pkg::ST_OK;
          out_key <= '0;
          out_tag <= '0;
          cur.key <= item.key;
          cur.tag <= item.tag;
          case (item.cmd)
            bhq_pkg::CMD_PUSH: begin
              pos <= fill_count[AW-1:0];
              if (fill_count >= CW'(bhq_pkg::CAPACITY)) begin
                status <= bhq_pkg::ST_FULL;
              end
            end
            bhq_pkg::CMD_POP: begin
              pos <= '0;
              if (fill_count == '0) begin
                status <= bhq_pkg::ST_EMPTY;
              end
            end
            bhq_pkg::CMD_EDIT: begin
              pos <= AW'(item.slot);
              if (CW'(item.slot) >= fill_count) begin
                status <= bhq_pkg::ST_RANGE;
              end
            end
            default: pos <= '0;
          endcase
        end
      end
      bhq_pkg::S_RD_LAST: begin
        out_key <= rd_entry.key;
        out_tag <= rd_entry.tag;
      end
      bhq_pkg::S_GET_LAST: begin
        cur <= rd_entry;
        pos <= '0;
      end
      bhq_pkg::S_ED_CMP: cur.tag <= rd_entry.tag;
      bhq_pkg::S_UP_CMP: begin
        if (lift_more) begin
          pos <= parent_idx;
        end
      end
      bhq_pkg::S_DN_RL: lft <= rd_entry;
      bhq_pkg::S_DN_RR: begin
        if (sink_more) begin
          pos <= best_idx;
        end
      end
      default: pos <= pos;
    endcase
  end

endmodule

`default_nettype wire
